FILE: rtl/gspd_pkg.sv
// Shared types, widths, register codes and gain tables of the PD steering block.
package gspd_pkg;

  localparam int unsigned ErrW      = 13;
  localparam int unsigned ActW      = 4;
  localparam int unsigned ConW      = 12;
  localparam int unsigned DriveW    = 10;
  localparam int unsigned SpeedW    = 9;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 12;
  localparam int unsigned KpW       = 13;
  localparam int unsigned KdW       = 6;

  localparam logic [7:0]  BaseSpeedRst   = 8'd100;
  localparam logic [11:0] MinContrastRst = 12'd400;
  localparam logic [11:0] CurveThrRst    = 12'd1200;
  localparam logic [11:0] HardThrRst     = 12'd1500;
  localparam logic [11:0] CornerThrRst   = 12'd1650;
  localparam logic [11:0] UshapeThrRst   = 12'd1950;
  localparam logic [7:0]  OutLimitRst    = 8'd180;

  localparam logic signed [ErrW-1:0] PeakError = 13'sd3500;
  localparam logic [ActW-1:0] PeakActive   = 4'd6;
  localparam logic [ActW-1:0] CornerActive = 4'd5;

  typedef enum logic [2:0] {
    MODE_STRAIGHT = 3'd0,
    MODE_SLIGHT   = 3'd1,
    MODE_CORNER   = 3'd2,
    MODE_UTURN    = 3'd3,
    MODE_PEAK     = 3'd4,
    MODE_LOST     = 3'd5
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_SPEED   = 3'd0,
    CFG_MIN_CONTRAST = 3'd1,
    CFG_CURVE_THR    = 3'd2,
    CFG_HARD_THR     = 3'd3,
    CFG_CORNER_THR   = 3'd4,
    CFG_USHAPE_THR   = 3'd5,
    CFG_OUTPUT_LIMIT = 3'd6
  } cfg_idx_e;

  // Proportional gain in Q0.16.
  function automatic logic [KpW-1:0] kp_of(mode_e m);
    logic [KpW-1:0] k;
    case (m)
      MODE_STRAIGHT: k = 13'd655;
      MODE_SLIGHT:   k = 13'd1311;
      MODE_CORNER:   k = 13'd2949;
      MODE_UTURN:    k = 13'd2949;
      MODE_PEAK:     k = 13'd6554;
      MODE_LOST:     k = 13'd2294;
      default:       k = 13'd655;
    endcase
    return k;
  endfunction

  // Derivative gain in Q2.4.
  function automatic logic [KdW-1:0] kd_of(mode_e m);
    logic [KdW-1:0] k;
    case (m)
      MODE_STRAIGHT: k = 6'd16;
      MODE_SLIGHT:   k = 6'd24;
      MODE_CORNER:   k = 6'd56;
      MODE_UTURN:    k = 6'd56;
      MODE_PEAK:     k = 6'd16;
      MODE_LOST:     k = 6'd32;
      default:       k = 6'd16;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] speed_drop_of(mode_e m);
    logic [7:0] d;
    case (m)
      MODE_CORNER: d = 8'd50;
      MODE_UTURN:  d = 8'd60;
      MODE_PEAK:   d = 8'd140;
      default:     d = 8'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/gspd_sample_if.sv
// Request channel that carries one sensor sample.
interface gspd_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gspd_pkg::ErrW-1:0]     line_error;
  logic        [gspd_pkg::ActW-1:0]     active_count;
  logic        [gspd_pkg::ConW-1:0]     contrast;

  modport source (output valid, line_error, active_count, contrast, input ready);
  modport sink   (input valid, line_error, active_count, contrast, output ready);
endinterface

FILE: rtl/gspd_result_if.sv
// Request channel that carries one steering result.
interface gspd_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gspd_pkg::DriveW-1:0]   left_drive;
  logic signed [gspd_pkg::DriveW-1:0]   right_drive;
  gspd_pkg::mode_e                      track_mode;
  logic signed [gspd_pkg::ErrW-1:0]     corrected_error;
  logic signed [gspd_pkg::SpeedW-1:0]   cruise_speed;
  logic                                 output_clamped;

  modport source (output valid, left_drive, right_drive, track_mode, corrected_error,
                  cruise_speed, output_clamped, input ready);
  modport sink   (input valid, left_drive, right_drive, track_mode, corrected_error,
                  cruise_speed, output_clamped, output ready);
endinterface

FILE: rtl/gain_scheduled_pd_line_steering.sv
// Gain-scheduled PD steering: mode classification, PD correction and drive mix.
//
// Usage: sensor samples arrive as requests on sample_i (valid/ready, accepted
// when both are high). Each sample yields exactly one request on result_o
// with the left and right drive commands, the track mode, the error used by
// the PD, the cruise speed and a clamp flag.
// An accepted sample is held in the input register, and its result is then
// registered in the result register, which drives result_o.valid. Throughput
// is one sample per cycle while the receiver takes each result; the figure
// is set by the previous-error register, which is updated as each sample
// moves from the input register into the result register.
// When the receiver stalls, the result register holds, the input register
// fills, and sample_i.ready drops until the result is taken.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
// must write it only while the block is idle, which the block does not enforce;
// an index beyond the last register is ignored. Reset puts all configuration
// registers at their defaults, clears the previous error, empties both pipeline registers.
module gain_scheduled_pd_line_steering (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gspd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [gspd_pkg::CfgDataW-1:0]     cfg_data_i,
  gspd_sample_if.sink                       sample_i,
  gspd_result_if.source                     result_o
);
  import gspd_pkg::*;

  localparam int unsigned SumW = 34;

  // Configuration registers.
  logic [7:0]  cruise_base_q;
  logic [11:0] min_contrast_q, curve_thr_q, hard_thr_q, corner_thr_q, ushape_thr_q;
  logic [7:0]  out_limit_q;

  // Input register.
  logic                   s1_valid_q;
  logic signed [ErrW-1:0] s1_err_q;
  logic [ActW-1:0]        s1_act_q;
  logic [ConW-1:0]        s1_con_q;

  // Loop state.
  logic signed [ErrW-1:0] prev_err_q;

  // Result register.
  logic                     out_valid_q;
  logic signed [DriveW-1:0] left_q, right_q;
  mode_e                    mode_q;
  logic signed [ErrW-1:0]   fixed_err_q;
  logic signed [SpeedW-1:0] speed_q;
  logic                     clamped_q;

  logic advance;
  assign advance = s1_valid_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready = !s1_valid_q || advance;

  // Classification.
  logic [ErrW-1:0]        aerr, alast;
  logic signed [ErrW:0]   err_neg, last_neg;
  mode_e                  mode_d;
  logic signed [ErrW-1:0] fixed_err_d;

  assign err_neg  = -{s1_err_q[ErrW-1], s1_err_q};
  assign last_neg = -{prev_err_q[ErrW-1], prev_err_q};
  assign aerr  = s1_err_q[ErrW-1]   ? err_neg[ErrW-1:0]  : s1_err_q;
  assign alast = prev_err_q[ErrW-1] ? last_neg[ErrW-1:0] : prev_err_q;

  always_comb begin
    if (s1_con_q < min_contrast_q || s1_act_q == '0) begin
      mode_d = MODE_LOST;
    end else if (s1_act_q >= PeakActive && alast > {1'b0, hard_thr_q}) begin
      mode_d = MODE_PEAK;
    end else if (aerr >= {1'b0, ushape_thr_q}) begin
      mode_d = MODE_UTURN;
    end else if (aerr >= {1'b0, corner_thr_q} ||
                 (s1_act_q >= CornerActive && aerr > {1'b0, hard_thr_q})) begin
      mode_d = MODE_CORNER;
    end else if (aerr >= {1'b0, curve_thr_q}) begin
      mode_d = MODE_SLIGHT;
    end else begin
      mode_d = MODE_STRAIGHT;
    end

    case (mode_d)
      MODE_LOST: fixed_err_d = prev_err_q;
      MODE_PEAK: fixed_err_d = (prev_err_q > 0) ? PeakError : -PeakError;
      default:   fixed_err_d = s1_err_q;
    endcase
  end

  // PD sum in Q.16.
  logic signed [ErrW:0]     diff;
  logic signed [26:0]       prod_p;
  logic signed [19:0]       prod_d;
  logic signed [SumW-1:0]   sum, lim, sum_c, sum_b;
  logic                     clamped_d;
  logic signed [SpeedW-1:0] pid;
  logic signed [SpeedW-1:0] speed_d;
  logic signed [DriveW-1:0] left_d, right_d;

  assign diff   = {fixed_err_d[ErrW-1], fixed_err_d} - {prev_err_q[ErrW-1], prev_err_q};
  assign prod_p = signed'({{14{fixed_err_d[ErrW-1]}}, fixed_err_d})
                * signed'({14'd0, kp_of(mode_d)});
  assign prod_d = signed'({{6{diff[ErrW]}}, diff}) * signed'({14'd0, kd_of(mode_d)});
  assign sum    = signed'({{7{prod_p[26]}}, prod_p})
                + signed'({{2{prod_d[19]}}, prod_d, 12'd0});
  assign lim    = signed'({10'd0, out_limit_q, 16'd0});

  always_comb begin
    clamped_d = 1'b0;
    sum_c     = sum;
    if (sum > lim) begin
      sum_c     = lim;
      clamped_d = 1'b1;
    end else if (sum < -lim) begin
      sum_c     = -lim;
      clamped_d = 1'b1;
    end
  end

  // Bias negative values so the arithmetic shift truncates toward zero.
  assign sum_b   = sum_c + (sum_c[SumW-1] ? SumW'(16'hFFFF) : SumW'(0));
  assign pid     = sum_b[24:16];
  assign speed_d = signed'({1'b0, cruise_base_q}) - signed'({1'b0, speed_drop_of(mode_d)});
  assign left_d  = {speed_d[SpeedW-1], speed_d} + {pid[SpeedW-1], pid};
  assign right_d = {speed_d[SpeedW-1], speed_d} - {pid[SpeedW-1], pid};

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cruise_base_q  <= BaseSpeedRst;
      min_contrast_q <= MinContrastRst;
      curve_thr_q    <= CurveThrRst;
      hard_thr_q     <= HardThrRst;
      corner_thr_q   <= CornerThrRst;
      ushape_thr_q   <= UshapeThrRst;
      out_limit_q    <= OutLimitRst;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      prev_err_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BASE_SPEED:   cruise_base_q  <= cfg_data_i[7:0];
          CFG_MIN_CONTRAST: min_contrast_q <= cfg_data_i;
          CFG_CURVE_THR:    curve_thr_q    <= cfg_data_i;
          CFG_HARD_THR:     hard_thr_q     <= cfg_data_i;
          CFG_CORNER_THR:   corner_thr_q   <= cfg_data_i;
          CFG_USHAPE_THR:   ushape_thr_q   <= cfg_data_i;
          CFG_OUTPUT_LIMIT: out_limit_q    <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (sample_i.ready) begin
        s1_valid_q <= sample_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        prev_err_q  <= fixed_err_d;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      s1_err_q <= sample_i.line_error;
      s1_act_q <= sample_i.active_count;
      s1_con_q <= sample_i.contrast;
    end
    if (advance) begin
      left_q      <= left_d;
      right_q     <= right_d;
      mode_q      <= mode_d;
      fixed_err_q <= fixed_err_d;
      speed_q     <= speed_d;
      clamped_q   <= clamped_d;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.left_drive      = left_q;
  assign result_o.right_drive     = right_q;
  assign result_o.track_mode      = mode_q;
  assign result_o.corrected_error = fixed_err_q;
  assign result_o.cruise_speed    = speed_q;
  assign result_o.output_clamped  = clamped_q;

endmodule
